[design/cca_pkg.sv]
// ----------------------------------------------------------------------------
// cca_pkg
// Shared constants, types and codes of the contiguous chunk allocator.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int HEAP_CHUNKS = 256;
    localparam int CHUNK_SHIFT = 20;
    localparam int ADDR_W      = 48;
    localparam int LEN_W       = 9;
    localparam int STATUS_W    = 2;
    localparam int SMALL_RUN   = 2;

    localparam int CHUNK_W = $clog2(HEAP_CHUNKS);
    localparam int CNT_W   = $clog2(HEAP_CHUNKS + 1);
    localparam int FIRST_W = ADDR_W - CHUNK_SHIFT;
    localparam int PTR_W   = FIRST_W + 1;
    localparam int SUM_W   = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_NO_RUN  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN1,
        S_SCAN2,
        S_MARK,
        S_FREE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_MARK,
        OP_FREE_INIT,
        OP_FREE,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic len_zero;
        logic over_count;
        logic hit;
        logic scan_end;
        logic step_last;
    } t_dp_sts;

endpackage

[design/cca_ctrl.sv]
// ----------------------------------------------------------------------------
// cca_ctrl
// Request sequencer: decides, walks the search, marks or frees, hands off.
// ----------------------------------------------------------------------------
module cca_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  cca_pkg::t_dp_sts i_sts,
    output cca_pkg::t_dp_cmd o_cmd
);
    import cca_pkg::*;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_out_valid, n_out_valid;
    logic    slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.is_free) begin
                    if (i_sts.len_zero) begin
                        n_code  = ST_OK;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FREE;
                    end
                end else if (i_sts.over_count) begin
                    n_code  = ST_REFUSED;
                    n_state = S_DONE;
                end else if (i_sts.len_zero) begin
                    n_code  = ST_NO_RUN;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (i_sts.hit) n_state = S_MARK;
                else if (i_sts.scan_end) n_state = S_SCAN2;
            end
            S_SCAN2: begin
                if (i_sts.hit) begin
                    n_state = S_MARK;
                end else if (i_sts.scan_end) begin
                    n_code  = ST_NO_RUN;
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                if (i_sts.step_last) begin
                    n_code  = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                if (i_sts.step_last) begin
                    n_code  = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.code = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_DECIDE: begin
                if (i_sts.is_free) begin
                    if (!i_sts.len_zero) o_cmd.op = OP_FREE_INIT;
                end else if (!i_sts.over_count && !i_sts.len_zero) begin
                    o_cmd.op = OP_SCAN_INIT;
                end
            end
            S_SCAN1: o_cmd.op = OP_SCAN;
            S_SCAN2: o_cmd.op = OP_SCAN;
            S_MARK:  o_cmd.op = OP_MARK;
            S_FREE:  o_cmd.op = OP_FREE;
            S_DONE: begin
                if (slot_free) o_cmd.op = OP_OUT;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.op == OP_OUT) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result dropped while output word still pending");

    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |=> r_out_valid)
        else $error("output word not presented after load");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |=> (r_state == S_DECIDE))
        else $error("accepted word not decided");

endmodule

[design/cca_dp.sv]
// ----------------------------------------------------------------------------
// cca_dp
// Datapath: used bitmap, count, cursor, base register, scan and step counters.
// ----------------------------------------------------------------------------
module cca_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cca_pkg::ADDR_W-1:0]     i_cfg_data,
    input  logic                           i_req_type,
    input  logic [cca_pkg::ADDR_W-1:0]     i_free_address,
    input  logic [cca_pkg::LEN_W-1:0]      i_run_length,
    input  cca_pkg::t_dp_cmd               i_cmd,
    output cca_pkg::t_dp_sts               o_sts,
    output logic [cca_pkg::STATUS_W-1:0]   o_status,
    output logic [cca_pkg::ADDR_W-1:0]     o_granted_address
);
    import cca_pkg::*;

    logic [HEAP_CHUNKS-1:0] r_map, n_map;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_cursor, n_cursor;
    logic [ADDR_W-1:0]      r_base, n_base;

    t_req                   r_req, n_req;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [CHUNK_W-1:0]     r_p, n_p;
    logic [CNT_W-1:0]       r_run, n_run;
    logic [PTR_W-1:0]       r_ptr, n_ptr;
    logic [CHUNK_W-1:0]     r_start, n_start;
    logic [FIRST_W-1:0]     r_first, n_first;
    logic [LEN_W-1:0]       r_step, n_step;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [ADDR_W-1:0]      r_granted, n_granted;

    logic                   scan_bit;
    logic                   scan_end;
    logic                   hit;
    logic                   step_last;
    logic                   ptr_in_heap;
    logic [PTR_W-1:0]       start_w;
    logic [ADDR_W-1:0]      offset;
    logic [SUM_W-1:0]       need;

    assign scan_bit    = r_map[r_p];
    assign scan_end    = (r_p == CHUNK_W'(HEAP_CHUNKS - 1));
    assign hit         = !scan_bit && ((SUM_W'(r_run) + SUM_W'(1)) == SUM_W'(r_len));
    assign step_last   = (r_step == (r_len - LEN_W'(1)));
    assign ptr_in_heap = (r_ptr < PTR_W'(HEAP_CHUNKS));
    assign start_w     = PTR_W'(r_p) + PTR_W'(1) - PTR_W'(r_len);
    assign offset      = r_addr - r_base;
    assign need        = SUM_W'(r_count) + SUM_W'(r_len);

    assign o_sts.is_free    = (r_req == REQ_FREE);
    assign o_sts.len_zero   = (r_len == '0);
    assign o_sts.over_count = (need >= SUM_W'(HEAP_CHUNKS));
    assign o_sts.hit        = hit;
    assign o_sts.scan_end   = scan_end;
    assign o_sts.step_last  = step_last;

    always_comb begin
        n_map     = r_map;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_base    = i_cfg_we ? i_cfg_data : r_base;
        n_req     = r_req;
        n_addr    = r_addr;
        n_len     = r_len;
        n_p       = r_p;
        n_run     = r_run;
        n_ptr     = r_ptr;
        n_start   = r_start;
        n_first   = r_first;
        n_step    = r_step;
        n_status  = r_status;
        n_granted = r_granted;
        case (i_cmd.op)
            OP_LOAD: begin
                n_req  = t_req'(i_req_type);
                n_addr = i_free_address;
                n_len  = i_run_length;
            end
            OP_SCAN_INIT: begin
                n_p   = (r_cursor == CNT_W'(HEAP_CHUNKS)) ? '0 : r_cursor[CHUNK_W-1:0];
                n_run = '0;
            end
            OP_SCAN: begin
                if (hit) begin
                    n_ptr   = start_w;
                    n_start = start_w[CHUNK_W-1:0];
                    n_step  = '0;
                end else if (scan_bit || scan_end) begin
                    n_run = '0;
                end else begin
                    n_run = r_run + CNT_W'(1);
                end
                n_p = scan_end ? '0 : r_p + CHUNK_W'(1);
            end
            OP_MARK: begin
                n_map[r_ptr[CHUNK_W-1:0]] = 1'b1;
                n_ptr  = r_ptr + PTR_W'(1);
                n_step = r_step + LEN_W'(1);
                if (step_last) begin
                    n_count = r_count + CNT_W'(r_len);
                    if (r_len <= LEN_W'(SMALL_RUN)) begin
                        n_cursor = CNT_W'(r_start) + CNT_W'(r_len);
                    end
                end
            end
            OP_FREE_INIT: begin
                n_first = offset[ADDR_W-1:CHUNK_SHIFT];
                n_ptr   = PTR_W'(offset[ADDR_W-1:CHUNK_SHIFT]);
                n_step  = '0;
            end
            OP_FREE: begin
                if (ptr_in_heap && r_map[r_ptr[CHUNK_W-1:0]]) begin
                    n_map[r_ptr[CHUNK_W-1:0]] = 1'b0;
                    n_count = r_count - CNT_W'(1);
                end
                n_ptr  = r_ptr + PTR_W'(1);
                n_step = r_step + LEN_W'(1);
                if (step_last && (r_first < FIRST_W'(r_cursor))) begin
                    n_cursor = CNT_W'(r_first);
                end
            end
            OP_OUT: begin
                n_status = i_cmd.code;
                if (i_cmd.code == ST_OK && r_req == REQ_ALLOC) begin
                    n_granted = r_base + (ADDR_W'(r_start) << CHUNK_SHIFT);
                end else begin
                    n_granted = '0;
                end
            end
            default: n_map = r_map;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map    <= '0;
            r_count  <= '0;
            r_cursor <= '0;
            r_base   <= '0;
        end else begin
            r_map    <= n_map;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_base   <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_addr    <= n_addr;
        r_len     <= n_len;
        r_p       <= n_p;
        r_run     <= n_run;
        r_ptr     <= n_ptr;
        r_start   <= n_start;
        r_first   <= n_first;
        r_step    <= n_step;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign o_status          = r_status;
    assign o_granted_address = r_granted;

    a_count_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(HEAP_CHUNKS))
        else $error("used count reached heap size");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CNT_W'(HEAP_CHUNKS))
        else $error("search cursor out of range");

    a_mark_target_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_MARK) |-> !r_map[r_ptr[CHUNK_W-1:0]])
        else $error("marking a chunk already in use");

endmodule

[design/contiguous_chunk_allocator_core.sv]
// ----------------------------------------------------------------------------
// contiguous_chunk_allocator_core
// Next-fit bitmap allocator of contiguous chunk runs in a fixed-size heap.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  cfg       i_cfg_we                  i_cfg_data (heap base)
//  request   i_in_valid / o_in_ready   i_req_type, i_free_address, i_run_length
//  result    o_out_valid / i_out_ready o_status, o_granted_address
//
//  One request at a time. Refused or zero-length requests go straight from
//  decide to done. Free steps through run_length chunks; allocate walks the
//  bitmap one bit per cycle from the cursor up and then from chunk zero up.
//  Reset clears the bitmap, count, cursor and base at once; no sweep.
//  A pending result blocks only the hand-off of the next one.
// ----------------------------------------------------------------------------
module contiguous_chunk_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cca_pkg::ADDR_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [cca_pkg::ADDR_W-1:0]     i_free_address,
    input  logic [cca_pkg::LEN_W-1:0]      i_run_length,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [cca_pkg::STATUS_W-1:0]   o_status,
    output logic [cca_pkg::ADDR_W-1:0]     o_granted_address
);
    import cca_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    cca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cca_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_free_address    (i_free_address),
        .i_run_length      (i_run_length),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_status          (o_status),
        .o_granted_address (o_granted_address)
    );

endmodule

[tb/cca_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cca_tb_pkg
// Grant tracker for the contiguous chunk allocator testbench. It keeps its own
// copy of the chunk map, used count, next-fit cursor and heap base. For every
// accepted request it queues the status and address the block must return,
// and it checks each returned word against the oldest queued grant.
// ----------------------------------------------------------------------------
package cca_tb_pkg;

    import cca_pkg::*;

    class chunk_grant_tracker;

        typedef struct {
            t_status            status;
            logic [ADDR_W-1:0]  address;
        } t_grant;

        typedef struct {
            int start;
            int length;
        } t_run;

        t_grant            grants_due[$];
        t_run              live_runs[$];
        bit                used_map[HEAP_CHUNKS];
        int                used_count;
        int                cursor;
        logic [ADDR_W-1:0] heap_base;
        int                errors;

        function new();
            foreach (used_map[i]) used_map[i] = 1'b0;
            used_count = 0;
            cursor     = 0;
            heap_base  = '0;
            errors     = 0;
        endfunction

        function void set_base(logic [ADDR_W-1:0] base);
            heap_base = base;
        endfunction

        function t_grant allocate_run(int n);
            t_grant g;
            int     chunk;
            bit     clear;
            t_run   r;
            g.status  = ST_OK;
            g.address = '0;
            if (used_count + n >= HEAP_CHUNKS) begin
                g.status = ST_REFUSED;
                return g;
            end
            if (n == 0) begin
                g.status = ST_NO_RUN;
                return g;
            end
            chunk = cursor;
            for (int i = 0; i < HEAP_CHUNKS; i++) begin
                if (chunk + n > HEAP_CHUNKS) chunk = 0;
                clear = 1'b1;
                for (int j = 0; j < n; j++) begin
                    if (used_map[chunk + j]) clear = 1'b0;
                end
                if (!clear) begin
                    chunk++;
                    continue;
                end
                for (int j = 0; j < n; j++) used_map[chunk + j] = 1'b1;
                used_count += n;
                if (n <= SMALL_RUN) cursor = chunk + n;
                g.address = heap_base + (ADDR_W'(chunk) << CHUNK_SHIFT);
                r.start   = chunk;
                r.length  = n;
                live_runs.push_back(r);
                return g;
            end
            g.status = ST_NO_RUN;
            return g;
        endfunction

        function void release_run(logic [ADDR_W-1:0] address, int n);
            logic [ADDR_W-1:0] offset;
            longint            first;
            offset = address - heap_base;
            first  = longint'(offset >> CHUNK_SHIFT);
            if (n == 0) return;
            for (int i = 0; i < n; i++) begin
                if (first + i < HEAP_CHUNKS && used_map[int'(first + i)]) begin
                    used_map[int'(first + i)] = 1'b0;
                    used_count--;
                end
            end
            if (first < cursor) cursor = int'(first);
        endfunction

        function void note_request(t_req kind, logic [ADDR_W-1:0] address,
                                   logic [LEN_W-1:0] length);
            t_grant g;
            g.status  = ST_OK;
            g.address = '0;
            if (kind == REQ_ALLOC) begin
                g = allocate_run(int'(length));
            end else begin
                release_run(address, int'(length));
            end
            grants_due.push_back(g);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] address);
            t_grant g;
            if (grants_due.size() == 0) begin
                $error("result word with no request pending: status %0d address %h",
                       status, address);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            if (status !== g.status) begin
                $error("status: expected %0d, actual %0d", g.status, status);
                errors++;
            end
            if (address !== g.address) begin
                $error("granted_address: expected %h, actual %h", g.address, address);
                errors++;
            end
        endfunction

        function bit take_run(output int start, output int length);
            int pick;
            if (live_runs.size() == 0) return 1'b0;
            pick   = $urandom_range(0, live_runs.size() - 1);
            start  = live_runs[pick].start;
            length = live_runs[pick].length;
            live_runs.delete(pick);
            return 1'b1;
        endfunction

    endclass

endpackage

[tb/contiguous_chunk_allocator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_chunk_allocator_core_tb
// Self-checking bench for the next-fit chunk allocator. A directed run covers
// zero and overlong lengths, the count refusal at a nearly full heap, frees of
// unused chunks, beyond the heap and below the base, a search that wraps to
// chunk zero and a search that finds no run. Random phases under several heap
// bases then mix allocations of mostly small runs with frees of live runs and
// stray requests, with random gaps on both channels.
// ----------------------------------------------------------------------------
module contiguous_chunk_allocator_core_tb;

    import cca_pkg::*;
    import cca_tb_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 172;
    localparam int DRAIN_WAIT  = 20;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_cfg_we          = 1'b0;
    logic [ADDR_W-1:0]   i_cfg_data        = '0;
    logic                i_in_valid        = 1'b0;
    logic                o_in_ready;
    logic                i_req_type        = 1'b0;
    logic [ADDR_W-1:0]   i_free_address    = '0;
    logic [LEN_W-1:0]    i_run_length      = '0;
    logic                o_out_valid;
    logic                i_out_ready       = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ADDR_W-1:0]   o_granted_address;

    chunk_grant_tracker tracker;
    bit                 quiet      = 1'b0;
    bit                 valid_held = 1'b0;
    int                 next_gap   = 0;
    int                 idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    contiguous_chunk_allocator_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_free_address    (i_free_address),
        .i_run_length      (i_run_length),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_granted_address (o_granted_address)
    );

    function int draw_wait();
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    function logic [ADDR_W-1:0] chunk_addr(int chunk);
        return tracker.heap_base + (ADDR_W'(chunk) << CHUNK_SHIFT);
    endfunction

    function logic [ADDR_W-1:0] noise_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic send_word(t_req kind, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
        repeat (next_gap) @(posedge i_clk);
        i_in_valid     <= 1'b1;
        i_req_type     <= kind;
        i_free_address <= addr;
        i_run_length   <= len;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(kind, addr, len);
        next_gap   = draw_wait();
        valid_held = (next_gap == 0);
        if (!valid_held) i_in_valid <= 1'b0;
    endtask

    task automatic stop_words();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    task automatic write_base(logic [ADDR_W-1:0] base);
        stop_words();
        while (tracker.grants_due.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_base(base);
    endtask

    task automatic random_word();
        int roll;
        int pick;
        int start;
        int length;
        int free_share;
        roll       = $urandom_range(0, 99);
        free_share = (tracker.used_count > 200) ? 70 : 38;
        if (roll < 6) begin
            if (roll < 2) begin
                send_word(REQ_ALLOC, noise_addr(), '0);
            end else if (roll < 4) begin
                send_word(REQ_FREE,
                          chunk_addr($urandom_range(0, 300)) + ADDR_W'($urandom),
                          LEN_W'($urandom_range(0, 511)));
            end else begin
                send_word(REQ_FREE, noise_addr(), LEN_W'($urandom_range(0, 511)));
            end
        end else if (roll < 6 + free_share && tracker.take_run(start, length)) begin
            if ($urandom_range(0, 6) == 0) length = $urandom_range(1, length);
            send_word(REQ_FREE,
                      chunk_addr(start) + ADDR_W'($urandom_range(0, (1 << CHUNK_SHIFT) - 1)),
                      LEN_W'(length));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      length = $urandom_range(1, 4);
            else if (pick < 85) length = $urandom_range(5, 32);
            else if (pick < 97) length = $urandom_range(33, 255);
            else                length = $urandom_range(256, 511);
            send_word(REQ_ALLOC, noise_addr(), LEN_W'(length));
        end
    endtask

    // result side: random stall before each word, check at hand-off
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        stall = draw_wait();
        forever begin
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.check_result(o_status, o_granted_address);
            stall = draw_wait();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [ADDR_W-1:0] bases [PHASES];
        tracker = new();
        bases[0] = '1;
        bases[1] = {ADDR_W'($urandom) << CHUNK_SHIFT};
        bases[2] = noise_addr();
        bases[3] = '0;
        bases[4] = 48'hFFFF_F000_0123;
        bases[5] = noise_addr();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_base('0);

        // lengths at the extremes, count refusal near full heap
        send_word(REQ_ALLOC, noise_addr(), '0);
        send_word(REQ_ALLOC, noise_addr(), 9'd511);
        send_word(REQ_ALLOC, noise_addr(), 9'd256);
        send_word(REQ_ALLOC, noise_addr(), 9'd255);
        send_word(REQ_ALLOC, noise_addr(), 9'd1);
        // zero-length, beyond-end and unused-chunk frees, then clear all
        send_word(REQ_FREE, chunk_addr(3) + 48'hF_FFFF, '0);
        send_word(REQ_FREE, '1, 9'd511);
        send_word(REQ_FREE, chunk_addr(255), 9'd1);
        send_word(REQ_FREE, chunk_addr(0) + 48'h8_0001, 9'd511);

        // leave holes behind the cursor, fill the rest, wrap to a hole
        send_word(REQ_ALLOC, noise_addr(), 9'd1);
        send_word(REQ_ALLOC, noise_addr(), 9'd1);
        send_word(REQ_ALLOC, noise_addr(), 9'd1);
        send_word(REQ_ALLOC, noise_addr(), 9'd1);
        send_word(REQ_ALLOC, noise_addr(), 9'd3);
        send_word(REQ_FREE, chunk_addr(1), 9'd1);
        send_word(REQ_FREE, chunk_addr(3), 9'd1);
        send_word(REQ_ALLOC, noise_addr(), 9'd2);
        send_word(REQ_ALLOC, noise_addr(), 9'd247);
        send_word(REQ_ALLOC, noise_addr(), 9'd1);
        // only single-chunk holes left: no run of two
        send_word(REQ_FREE, chunk_addr(100), 9'd1);
        send_word(REQ_FREE, chunk_addr(200), 9'd1);
        send_word(REQ_ALLOC, noise_addr(), 9'd2);
        send_word(REQ_FREE, chunk_addr(0), 9'd511);

        // below-base free wraps to a large chunk index
        write_base(48'h0000_4000_0000);
        send_word(REQ_ALLOC, noise_addr(), 9'd2);
        send_word(REQ_FREE, 48'h0000_0000_0000, 9'd2);

        for (int p = 0; p < PHASES; p++) begin
            write_base(bases[p]);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
                random_word();
            end
        end

        stop_words();
        while (tracker.grants_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.grants_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
design/cca_pkg.sv
design/cca_ctrl.sv
design/cca_dp.sv
design/contiguous_chunk_allocator_core.sv
tb/cca_tb_pkg.sv
tb/contiguous_chunk_allocator_core_tb.sv
